### rtl/pkseq_pkg.sv
`default_nettype none

package pkseq_pkg;

    localparam int KEY_ENTRIES_DEF = 16;
    localparam int HOLD_DEPTH_DEF  = 4;
    localparam int TAG_BITS_DEF    = 16;

    localparam int SEQ_W = 64;
    localparam int TAG_W = 16;

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_REPLY   = 1'b1;

    typedef enum logic [2:0] {
        ACT_SEND_SEQ   = 3'd0,
        ACT_SEND_UNSEQ = 3'd1,
        ACT_HELD       = 3'd2,
        ACT_REPLY      = 3'd3,
        ACT_TABLE_FULL = 3'd4,
        ACT_QUEUE_FULL = 3'd5,
        ACT_UNKNOWN    = 3'd6
    } t_action;

    typedef struct packed {
        logic             opcode;
        logic             has_sequence;
        logic [SEQ_W-1:0] sequence_id;
        logic [TAG_W-1:0] item_tag;
    } t_in_word;

    typedef struct packed {
        t_action          action;
        logic [TAG_W-1:0] out_tag;
        logic [SEQ_W-1:0] out_sequence_id;
        logic             last;
    } t_out_word;

    // Outcome of one lookup, handed from the key table to the output stage.
    typedef struct packed {
        t_action          action;
        logic             pop;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] seq;
    } t_decision;

endpackage

`default_nettype wire

### rtl/pkseq_table.sv
`default_nettype none

module pkseq_table #(
    parameter int KEY_ENTRIES = pkseq_pkg::KEY_ENTRIES_DEF,
    parameter int HOLD_DEPTH  = pkseq_pkg::HOLD_DEPTH_DEF,
    parameter int TAG_BITS    = pkseq_pkg::TAG_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire pkseq_pkg::t_in_word        i_word,
    output pkseq_pkg::t_decision            o_dec,
    output logic [pkseq_pkg::TAG_W-1:0]     o_held_tag
);

    localparam int KW    = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
    localparam int HW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW    = $clog2(HOLD_DEPTH + 1);
    localparam int DEPTH = KEY_ENTRIES * HOLD_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (TAG_BITS < pkseq_pkg::TAG_W) ? TAG_BITS : pkseq_pkg::TAG_W;
    localparam logic [pkseq_pkg::TAG_W-1:0] TagMask =
        pkseq_pkg::TAG_W'((32'd1 << TW) - 32'd1);
    localparam logic [CW-1:0] HoldFull = CW'(HOLD_DEPTH);
    localparam logic [HW-1:0] HeadLast = HW'(HOLD_DEPTH - 1);
    localparam logic [HW:0]   HoldSum  = (HW+1)'(HOLD_DEPTH);

    logic [KEY_ENTRIES-1:0]       r_busy;
    logic [pkseq_pkg::SEQ_W-1:0]  r_key   [KEY_ENTRIES];
    logic [HW-1:0]                r_head  [KEY_ENTRIES];
    logic [CW-1:0]                r_count [KEY_ENTRIES];
    logic [TW-1:0]                r_mem   [DEPTH];
    logic [TW-1:0]                r_held_q;

    logic [KEY_ENTRIES-1:0] hit_vec, hit_1h, free_vec, free_1h, sel_1h;
    logic                   hit, has_free;
    logic [KW-1:0]          idx;
    logic [HW-1:0]          head, head_inc, slot;
    logic [CW-1:0]          count;
    logic [HW:0]            slot_sum;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic                   push, claim, pop, release_key;

    // lowest-index match and lowest-index free entry
    always_comb begin
        for (int e = 0; e < KEY_ENTRIES; e++) begin
            hit_vec[e] = r_busy[e] && (r_key[e] == i_word.sequence_id);
        end
        free_vec = ~r_busy;
        hit_1h   = hit_vec & (~hit_vec + 1'b1);
        free_1h  = free_vec & (~free_vec + 1'b1);
        hit      = |hit_vec;
        has_free = |free_vec;
        sel_1h   = hit ? hit_1h : free_1h;
    end

    always_comb begin
        idx   = '0;
        head  = '0;
        count = '0;
        for (int e = 0; e < KEY_ENTRIES; e++) begin
            if (sel_1h[e]) begin
                idx   = idx | KW'(e);
                head  = head | r_head[e];
                count = count | r_count[e];
            end
        end
    end

    always_comb begin
        slot_sum = (HW+1)'(head) + (HW+1)'(count);
        slot     = (slot_sum >= HoldSum) ? HW'(slot_sum - HoldSum) : HW'(slot_sum);
        head_inc = (head == HeadLast) ? '0 : head + 1'b1;
        wr_addr  = AW'(idx) * AW'(HOLD_DEPTH) + AW'(slot);
        rd_addr  = AW'(idx) * AW'(HOLD_DEPTH) + AW'(head);
    end

    always_comb begin
        o_dec.action = pkseq_pkg::ACT_SEND_UNSEQ;
        o_dec.pop    = 1'b0;
        o_dec.tag    = i_word.item_tag & TagMask;
        o_dec.seq    = i_word.sequence_id;
        push         = 1'b0;
        claim        = 1'b0;
        pop          = 1'b0;
        release_key  = 1'b0;
        if (i_word.opcode == pkseq_pkg::OP_MESSAGE) begin
            if (!i_word.has_sequence) begin
                o_dec.action = pkseq_pkg::ACT_SEND_UNSEQ;
                o_dec.seq    = '0;
            end else if (hit) begin
                if (count >= HoldFull) begin
                    o_dec.action = pkseq_pkg::ACT_QUEUE_FULL;
                end else begin
                    o_dec.action = pkseq_pkg::ACT_HELD;
                    push         = 1'b1;
                end
            end else if (!has_free) begin
                o_dec.action = pkseq_pkg::ACT_TABLE_FULL;
            end else begin
                o_dec.action = pkseq_pkg::ACT_SEND_SEQ;
                claim        = 1'b1;
            end
        end else begin
            if (!hit) begin
                o_dec.action = pkseq_pkg::ACT_UNKNOWN;
            end else if (count != '0) begin
                // held word goes out first, the reply follows
                o_dec.action = pkseq_pkg::ACT_SEND_SEQ;
                o_dec.pop    = 1'b1;
                pop          = 1'b1;
            end else begin
                o_dec.action = pkseq_pkg::ACT_REPLY;
                release_key  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int e = 0; e < KEY_ENTRIES; e++) begin
                r_head[e]  <= '0;
                r_count[e] <= '0;
            end
        end else if (i_fire) begin
            if (claim) begin
                r_busy[idx]  <= 1'b1;
                r_head[idx]  <= '0;
                r_count[idx] <= '0;
            end
            if (push) begin
                r_count[idx] <= count + 1'b1;
            end
            if (pop) begin
                r_head[idx]  <= head_inc;
                r_count[idx] <= count - 1'b1;
            end
            if (release_key) begin
                r_busy[idx] <= 1'b0;
                r_head[idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && claim) begin
            r_key[idx] <= i_word.sequence_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && push) begin
            r_mem[wr_addr] <= i_word.item_tag[TW-1:0];
        end
        if (i_fire && pop) begin
            r_held_q <= r_mem[rd_addr];
        end
    end

    assign o_held_tag = pkseq_pkg::TAG_W'(r_held_q);

endmodule

`default_nettype wire

### rtl/per_key_in_order_sequencer.sv
// Per-key in-order sequencer: at most one message per sequence id is in flight.
// Input channel (i_in_valid / o_in_stall / i_in_word) carries messages from
// upstream (opcode message) and replies from downstream (opcode reply).
// Output channel (o_out_valid / i_out_stall / o_out_word) carries one action
// word per result; last marks the final word of an input.
// A word is taken into an input register, looked up against the key table
// once the output register can take its result, and the result registered.
// One input per cycle is sustained while the output is not stalled; a reply
// that releases a held message yields two output words, the held word and
// then the reply, and holds the input register until the held word is taken.
// The combinational loop is the parallel key compare plus the ring update.
// Held tags live in a KEY_ENTRIES*HOLD_DEPTH memory; its read data is
// registered together with the result.
// Reset clears the key table at once; no clearing pass is needed.
// When the receiver stalls, the output word holds, the input register keeps
// one more word, and o_in_stall rises once that register is occupied.
`default_nettype none

module per_key_in_order_sequencer #(
    parameter int KEY_ENTRIES = pkseq_pkg::KEY_ENTRIES_DEF,
    parameter int HOLD_DEPTH  = pkseq_pkg::HOLD_DEPTH_DEF,
    parameter int TAG_BITS    = pkseq_pkg::TAG_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire pkseq_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output pkseq_pkg::t_out_word      o_out_word
);

    logic                            r_in_valid;
    pkseq_pkg::t_in_word             r_in;
    logic                            r_o_valid;
    logic                            r_o_sec;
    logic                            r_o_mem;
    pkseq_pkg::t_action              r_o_action;
    logic [pkseq_pkg::TAG_W-1:0]     r_o_tag;
    logic [pkseq_pkg::SEQ_W-1:0]     r_o_seq;
    logic                            r_o_last;

    pkseq_pkg::t_decision            dec;
    logic [pkseq_pkg::TAG_W-1:0]     held_tag;
    logic                            out_free, fire, in_take, out_take;

    assign out_take   = r_o_valid && !i_out_stall;
    assign out_free   = !r_o_valid || (out_take && !r_o_sec);
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    pkseq_table #(
        .KEY_ENTRIES (KEY_ENTRIES),
        .HOLD_DEPTH  (HOLD_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_word     (r_in),
        .o_dec      (dec),
        .o_held_tag (held_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_sec   <= 1'b0;
            r_o_mem   <= 1'b0;
        end else if (fire) begin
            r_o_valid <= 1'b1;
            r_o_sec   <= dec.pop;
            r_o_mem   <= dec.pop;
        end else if (out_take) begin
            if (r_o_sec) begin
                r_o_sec <= 1'b0;
                r_o_mem <= 1'b0;
            end else begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // r_o_tag keeps the reply tag while the held word is shown first
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_action <= dec.action;
            r_o_tag    <= dec.tag;
            r_o_seq    <= dec.seq;
            r_o_last   <= !dec.pop;
        end else if (out_take && r_o_sec) begin
            r_o_action <= pkseq_pkg::ACT_REPLY;
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid                = r_o_valid;
    assign o_out_word.action          = r_o_action;
    assign o_out_word.out_tag         = r_o_mem ? held_tag : r_o_tag;
    assign o_out_word.out_sequence_id = r_o_seq;
    assign o_out_word.last            = r_o_last;

endmodule

`default_nettype wire
